[hw/rtl/sbra_pkg.sv]
// Shared types and constants for the segment bitmap range allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbra_pkg;

  localparam int SEG_W            = 9;
  localparam int NUM_SEGMENTS_DEF = 512;

  typedef logic [SEG_W-1:0] seg_t;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_CLAIM = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_ALLOC = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRY,
    ST_RD,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic wr_bit;
  } map_ctl_t;

  typedef struct packed {
    logic success;
    seg_t start;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/sbra_map.sv]
// Used-bit map memory: one bit per segment, one write and one registered read.
// Depends on sbra_pkg (map_ctl_t).
`default_nettype none

module sbra_map #(
  parameter int NUM_SEGMENTS = sbra_pkg::NUM_SEGMENTS_DEF,
  parameter int IDX_W        = $clog2(NUM_SEGMENTS)
) (
  input  logic                 clk_i,
  input  sbra_pkg::map_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]     addr_i,
  output logic                 rd_bit_o
);
  import sbra_pkg::*;

  logic mem_q [NUM_SEGMENTS];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= ctl_i.wr_bit;
    end
    rd_bit_q <= mem_q[addr_i];
  end

  assign rd_bit_o = rd_bit_q;

endmodule

`default_nettype wire

[hw/rtl/sbra_ctrl.sv]
// Sequencer: clearing pass, range walk and free-run scan, one segment bit per step.
// Depends on sbra_pkg; drives the sbra_map memory.
`default_nettype none

module sbra_ctrl #(
  parameter int NUM_SEGMENTS = sbra_pkg::NUM_SEGMENTS_DEF,
  parameter int IDX_W        = $clog2(NUM_SEGMENTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  sbra_pkg::action_e     action_i,
  input  sbra_pkg::seg_t        first_i,
  input  sbra_pkg::seg_t        last_i,
  input  sbra_pkg::seg_t        pref_i,
  input  sbra_pkg::seg_t        span_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  output sbra_pkg::res_t        res_o,
  input  logic                  res_take_i,
  output sbra_pkg::map_ctl_t    map_ctl_o,
  output logic [IDX_W-1:0]      map_addr_o,
  input  logic                  map_bit_i
);
  import sbra_pkg::*;

  localparam int CMP_W = ((IDX_W > SEG_W) ? IDX_W : SEG_W) + 1;

  state_e            st_q, st_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              claim_q, claim_d;
  action_e           act_q, act_d;
  seg_t              lo_q, lo_d, hi_q, hi_d, pref_q, pref_d, span_q, span_d;
  seg_t              c_q, c_d, p_q, p_d, end_q, end_d, start_q, start_d;
  logic              ok_q, ok_d;

  logic [CMP_W-1:0]  p_ext;
  logic              in_map, used, walk, wr_mode;
  logic [SEG_W:0]    sum, nxt;
  seg_t              cand;

  assign p_ext   = CMP_W'(p_q);
  assign in_map  = p_ext < CMP_W'(NUM_SEGMENTS);
  assign used    = !in_map || map_bit_i;
  assign walk    = (act_q == ACT_CHECK) || (act_q == ACT_CLAIM) || claim_q;
  assign wr_mode = (act_q == ACT_CLAIM) || claim_q;
  assign sum     = {1'b0, c_q} + {1'b0, span_q};
  assign nxt     = {1'b0, p_q} + {{SEG_W{1'b0}}, 1'b1};
  assign cand    = (nxt > {1'b0, hi_q}) ? lo_q : nxt[SEG_W-1:0];

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    claim_d   = claim_q;
    act_d     = act_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    pref_d    = pref_q;
    span_d    = span_q;
    c_d       = c_q;
    p_d       = p_q;
    end_d     = end_q;
    ok_d      = ok_q;
    start_d   = start_q;
    map_ctl_o = '0;
    map_addr_o = in_map ? p_ext[IDX_W-1:0] : '0;

    case (st_q)
      ST_CLEAR: begin
        map_ctl_o.wr_en = 1'b1;
        map_addr_o      = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == IDX_W'(NUM_SEGMENTS - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          act_d   = action_i;
          lo_d    = first_i;
          hi_d    = last_i;
          pref_d  = pref_i;
          span_d  = span_i;
          claim_d = 1'b0;
          ok_d    = 1'b0;
          start_d = '0;
          if ((action_i == ACT_CHECK) || (action_i == ACT_CLAIM)) begin
            if (first_i > last_i) begin
              ok_d = 1'b1;
              st_d = ST_DONE;
            end else begin
              p_d   = first_i;
              end_d = last_i;
              st_d  = ST_RD;
            end
          end else if ((first_i > last_i) || (pref_i < first_i) || (pref_i > last_i)) begin
            st_d = ST_DONE;
          end else begin
            c_d  = pref_i;
            st_d = ST_TRY;
          end
        end
      end
      ST_TRY: begin
        if (sum <= {1'b0, hi_q}) begin
          end_d = sum[SEG_W-1:0];
          p_d   = c_q;
          st_d  = ST_RD;
        end else if ((c_q < pref_q) || (lo_q == pref_q)) begin
          ok_d    = 1'b0;
          start_d = '0;
          st_d    = ST_DONE;
        end else begin
          c_d = lo_q;
        end
      end
      ST_RD: begin
        st_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (walk) begin
          if (used) begin
            ok_d    = 1'b0;
            start_d = '0;
            st_d    = ST_DONE;
          end else begin
            map_ctl_o.wr_en  = wr_mode;
            map_ctl_o.wr_bit = 1'b1;
            if (p_q == end_q) begin
              ok_d    = 1'b1;
              start_d = claim_q ? c_q : '0;
              st_d    = ST_DONE;
            end else begin
              p_d  = nxt[SEG_W-1:0];
              st_d = ST_RD;
            end
          end
        end else if (!used) begin
          if (p_q == end_q) begin
            if (act_q == ACT_ALLOC) begin
              claim_d = 1'b1;
              p_d     = c_q;
              st_d    = ST_RD;
            end else begin
              ok_d    = 1'b1;
              start_d = c_q;
              st_d    = ST_DONE;
            end
          end else begin
            p_d  = nxt[SEG_W-1:0];
            st_d = ST_RD;
          end
        end else if (((c_q < pref_q) && (pref_q <= p_q)) || (cand == pref_q)) begin
          // used segment skips every start up to it; a lap ends the scan
          ok_d    = 1'b0;
          start_d = '0;
          st_d    = ST_DONE;
        end else begin
          c_d  = cand;
          st_d = ST_TRY;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_CLEAR;
      clr_q   <= '0;
      claim_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      claim_q <= claim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    pref_q  <= pref_d;
    span_q  <= span_d;
    c_q     <= c_d;
    p_q     <= p_d;
    end_q   <= end_d;
    ok_q    <= ok_d;
    start_q <= start_d;
  end

  assign idle_o        = (st_q == ST_IDLE);
  assign res_valid_o   = (st_q == ST_DONE);
  assign res_o.success = ok_q;
  assign res_o.start   = start_q;

endmodule

`default_nettype wire

[hw/rtl/segment_bitmap_range_allocator.sv]
// Segment bitmap range allocator top level: request port, result register.
// Depends on sbra_pkg, sbra_map and sbra_ctrl.
//
// Usage: a request (action, first/last/preferred segment, span) is taken when
// in_valid_i is high and in_stall_o low; exactly one result (success_o,
// start_segment_o) follows on the out channel. in_stall_o is high while a
// request is being worked or while its result waits in the sequencer.
// The map is walked one segment bit at a time, each bit read (ST_RD) and then
// evaluated (ST_EVAL), through the single registered read port of the bitmap
// memory. A find visits each segment at most about twice (one read per probe),
// and an allocate walks its range again to claim it. Find and allocate requests
// with an empty region or a preference outside it are rejected without a map
// read. After reset the bitmap is cleared by a pass over every segment,
// during which no request is taken. The result sits in an output register;
// while out_stall_i is high it holds, and the next request may already be
// taken and worked; its result waits in the sequencer until the register
// frees.
`default_nettype none

module segment_bitmap_range_allocator #(
  parameter int NUM_SEGMENTS = sbra_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [sbra_pkg::SEG_W-1:0] first_segment_i,
  input  logic [sbra_pkg::SEG_W-1:0] last_segment_i,
  input  logic [sbra_pkg::SEG_W-1:0] preferred_segment_i,
  input  logic [sbra_pkg::SEG_W-1:0] span_segments_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      success_o,
  output logic [sbra_pkg::SEG_W-1:0] start_segment_o
);
  import sbra_pkg::*;

  localparam int IDX_W = $clog2(NUM_SEGMENTS);

  logic              idle;
  logic              res_valid;
  res_t              res;
  logic              load;
  map_ctl_t          map_ctl;
  logic [IDX_W-1:0]  map_addr;
  logic              map_bit;

  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  sbra_ctrl #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .action_i    (action_e'(action_i)),
    .first_i     (first_segment_i),
    .last_i      (last_segment_i),
    .pref_i      (preferred_segment_i),
    .span_i      (span_segments_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (load),
    .map_ctl_o   (map_ctl),
    .map_addr_o  (map_addr),
    .map_bit_i   (map_bit)
  );

  sbra_map #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .IDX_W        (IDX_W)
  ) u_map (
    .clk_i    (clk_i),
    .ctl_i    (map_ctl),
    .addr_i   (map_addr),
    .rd_bit_o (map_bit)
  );

  assign in_stall_o = !idle;
  assign load       = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign success_o       = out_q.success;
  assign start_segment_o = out_q.start;

endmodule

`default_nettype wire
